[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the statistics block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

[design/sss_pkg.sv]
// ----------------------------------------------------------------------------
// sss_pkg
// Types and constants shared by the sorted set statistics block.
// ----------------------------------------------------------------------------
`default_nettype none

package sss_pkg;

  localparam int MaxItems = 256;
  localparam int MarkW    = 16;
  localparam int SumW     = 24;
  localparam int CountW   = 9;
  localparam int Med2W    = 17;
  localparam int AddrW    = $clog2(MaxItems);
  localparam int CntW     = $clog2(MaxItems + 1);
  localparam int NumW     = SumW + 1;
  localparam int DivCntW  = $clog2(NumW + 1);
  localparam int OutDataW = 72;

  localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};

  typedef enum logic [0:0] {
    ST_LOAD,
    ST_CALC
  } top_state_e;

  typedef enum logic [3:0] {
    SORT_IDLE,
    SORT_READ_I,
    SORT_TAKE_I,
    SORT_SCAN,
    SORT_SWAP_LO,
    SORT_SWAP_I,
    SORT_MED_LO,
    SORT_MED_HI,
    SORT_MED_SUM
  } sort_state_e;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] addr;
    logic [MarkW-1:0] data;
  } ld_wr_t;

  typedef struct packed {
    logic            start;
    logic [CntW-1:0] n;
  } sort_req_t;

  typedef struct packed {
    logic             done;
    logic [Med2W-1:0] med2;
  } sort_rsp_t;

  typedef struct packed {
    logic            start;
    logic [NumW-1:0] num;
    logic [CntW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [MarkW-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

[design/sorted_set_statistics.sv]
// ----------------------------------------------------------------------------
// sorted_set_statistics
// Collects a set of marks, partly sorts them and reports count, sum, mean, median.
// ----------------------------------------------------------------------------
//
// Channel  Direction  Payload                               Accepted when
// s_*      in         tdata: mark[15:0]; tlast: last         s_tvalid_i && s_tready_o
// m_*      out        tdata: count, sum, mean, median x2;    m_tvalid_o && m_tready_i
//                     tuser: overflow
//
// Each mark is taken in one cycle while the set is loading. After the
// transaction that carries tlast, input stalls while the selection sort runs
// up to the middle entry on the value store (a write port and a registered
// read port), the median is read and summed, and the output register is
// loaded. The mean divider runs in parallel with the sort. Reset clears the
// control state; the value store is not cleared, since only entries written
// in the current set are ever read. A result waiting at the output does not
// hold off loading the next set; it only delays that set's own result.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sorted_set_statistics (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_tvalid_i,
  output logic             s_tready_o,
  input  wire logic [15:0] s_tdata_i,   // mark[15:0]
  input  wire logic        s_tlast_i,   // last
  output logic             m_tvalid_o,
  input  wire logic        m_tready_i,
  output logic [71:0]      m_tdata_o,   // count[8:0], sum_total[32:9], mean[48:33],
                                        // median_doubled[65:49], zero fill[71:66]
  output logic             m_tuser_o    // overflow
);

  sss_pkg::top_state_e state_q, state_d;

  logic [sss_pkg::CntW-1:0] count_q, count_d;
  logic [sss_pkg::SumW-1:0] sum_q, sum_d;
  logic                     drop_q, drop_d;

  logic                         m_tvalid_q;
  logic [sss_pkg::OutDataW-1:0] m_tdata_q;
  logic                         m_tuser_q;

  logic                     accept;
  logic                     room;
  logic [sss_pkg::SumW:0]   sum_ext;
  logic                     out_load;

  sss_pkg::ld_wr_t   ld_wr;
  sss_pkg::sort_req_t sort_req;
  sss_pkg::sort_rsp_t sort_rsp;
  sss_pkg::div_req_t  div_req;
  sss_pkg::div_rsp_t  div_rsp;

  // Handshake and output-register control.
  always_comb begin
    s_tready_o = state_q == sss_pkg::ST_LOAD;
    accept     = s_tvalid_i && s_tready_o;
    out_load   = (state_q == sss_pkg::ST_CALC) && sort_rsp.done && div_rsp.done &&
                 (!m_tvalid_q || m_tready_i);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sss_pkg::ST_LOAD: if (accept && s_tlast_i) state_d = sss_pkg::ST_CALC;
      sss_pkg::ST_CALC: if (out_load) state_d = sss_pkg::ST_LOAD;
      default:          state_d = sss_pkg::ST_LOAD;
    endcase
  end

  // Set accumulation. A mark that finds the store full is dropped and flagged;
  // the total saturates rather than wraps.
  always_comb begin
    room    = count_q < sss_pkg::CntW'(sss_pkg::MaxItems);
    sum_ext = {1'b0, sum_q} + {{(sss_pkg::SumW+1-sss_pkg::MarkW){1'b0}}, s_tdata_i};
    count_d = count_q;
    sum_d   = sum_q;
    drop_d  = drop_q;
    if (accept) begin
      if (room) begin
        count_d = count_q + 1'b1;
        sum_d   = sum_ext[sss_pkg::SumW] ? sss_pkg::SumMax : sum_ext[sss_pkg::SumW-1:0];
      end else begin
        drop_d = 1'b1;
      end
    end
    if (out_load) begin
      count_d = '0;
      sum_d   = '0;
      drop_d  = 1'b0;
    end
  end

  // The store write and both starts use the values that include the last mark.
  always_comb begin
    ld_wr.we       = accept && room;
    ld_wr.addr     = count_q[sss_pkg::AddrW-1:0];
    ld_wr.data     = s_tdata_i;
    sort_req.start = accept && s_tlast_i;
    sort_req.n     = count_d;
    div_req.start  = accept && s_tlast_i;
    div_req.den    = count_d;
    div_req.num    = {1'b0, sum_d} + sss_pkg::NumW'(count_d >> 1);
  end

  sss_sorter u_sorter (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ld_wr_i (ld_wr),
    .req_i   (sort_req),
    .rsp_o   (sort_rsp)
  );

  sss_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= sss_pkg::ST_LOAD;
      count_q    <= '0;
      sum_q      <= '0;
      drop_q     <= 1'b0;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      sum_q   <= sum_d;
      drop_q  <= drop_d;
      if (out_load) begin
        m_tvalid_q <= 1'b1;
      end else if (m_tready_i) begin
        m_tvalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_tdata_q <= {{(sss_pkg::OutDataW - sss_pkg::CountW - sss_pkg::SumW -
                      sss_pkg::MarkW - sss_pkg::Med2W){1'b0}},
                    sort_rsp.med2, div_rsp.quot, sum_q, count_q[sss_pkg::CountW-1:0]};
      m_tuser_q <= drop_q;
    end
  end

  assign m_tvalid_o = m_tvalid_q;
  assign m_tdata_o  = m_tdata_q;
  assign m_tuser_o  = m_tuser_q;

  `ASSERT_NEXT(a_stall_after_last, clk_i, rst_ni, accept && s_tlast_i, !s_tready_o)
  `ASSERT_IMPLIES(a_count_in_range, clk_i, rst_ni, 1'b1, count_q <= sss_pkg::CntW'(sss_pkg::MaxItems))
  `ASSERT_IMPLIES(a_result_from_calc, clk_i, rst_ni, $rose(m_tvalid_o), $past(state_q == sss_pkg::ST_CALC))

endmodule

`default_nettype wire

[design/sss_div.sv]
// ----------------------------------------------------------------------------
// sss_div
// Restoring divider, one quotient bit per cycle, for the rounded mean.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sss_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire sss_pkg::div_req_t req_i,
  output sss_pkg::div_rsp_t      rsp_o
);

  logic [sss_pkg::NumW-1:0]    num_q;
  logic [sss_pkg::CntW-1:0]    den_q;
  logic [sss_pkg::CntW:0]      rem_q;
  logic [sss_pkg::DivCntW-1:0] cnt_q;
  logic                        busy_q;
  logic                        done_q;

  logic [sss_pkg::CntW:0] shifted;
  logic [sss_pkg::CntW:0] diff;
  logic                   fits;

  always_comb begin
    shifted = {rem_q[sss_pkg::CntW-1:0], num_q[sss_pkg::NumW-1]};
    fits    = shifted >= {1'b0, den_q};
    diff    = shifted - {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (req_i.start) begin
      cnt_q  <= sss_pkg::DivCntW'(sss_pkg::NumW);
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == sss_pkg::DivCntW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // The quotient bits shift in at the bottom as the dividend shifts out.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= req_i.num;
      den_q <= req_i.den;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? diff : shifted;
      num_q <= {num_q[sss_pkg::NumW-2:0], fits};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = num_q[sss_pkg::MarkW-1:0];

  `ASSERT_NEXT(a_div_start_clears_done, clk_i, rst_ni, req_i.start, !done_q && busy_q)

endmodule

`default_nettype wire

[design/sss_sorter.sv]
// ----------------------------------------------------------------------------
// sss_sorter
// Value store with a selection sort sequencer and median readout.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sss_sorter (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire sss_pkg::ld_wr_t    ld_wr_i,
  input  wire sss_pkg::sort_req_t req_i,
  output sss_pkg::sort_rsp_t      rsp_o
);

  logic [sss_pkg::MarkW-1:0] mem_q [sss_pkg::MaxItems];
  logic [sss_pkg::MarkW-1:0] rdata_q;

  sss_pkg::sort_state_e state_q, state_d;

  logic [sss_pkg::CntW-1:0]  n_q;
  logic [sss_pkg::AddrW-1:0] i_q, i_d, j_q, j_d, lo_q, lo_d;
  logic [sss_pkg::MarkW-1:0] min_q, min_d, vali_q, vali_d, meda_q, meda_d;
  logic [sss_pkg::Med2W-1:0] med2_q, med2_d;
  logic                      done_q;

  logic                      we;
  logic [sss_pkg::AddrW-1:0] waddr;
  logic [sss_pkg::MarkW-1:0] wdata;
  logic [sss_pkg::AddrW-1:0] raddr;

  logic [sss_pkg::CntW-1:0]  half;
  logic [sss_pkg::CntW-1:0]  i_next;
  logic [sss_pkg::CntW-1:0]  j_next;
  logic                      i_more;
  logic                      j_more;
  logic                      i_last;

  always_comb begin
    half   = n_q >> 1;
    i_next = {{(sss_pkg::CntW-sss_pkg::AddrW){1'b0}}, i_q} + 1'b1;
    j_next = {{(sss_pkg::CntW-sss_pkg::AddrW){1'b0}}, j_q} + 1'b1;
    i_more = i_next < n_q;
    j_more = j_next < n_q;
    i_last = {{(sss_pkg::CntW-sss_pkg::AddrW){1'b0}}, i_q} == half;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sss_pkg::SORT_IDLE:    if (req_i.start) state_d = sss_pkg::SORT_READ_I;
      sss_pkg::SORT_READ_I:  state_d = sss_pkg::SORT_TAKE_I;
      sss_pkg::SORT_TAKE_I:  state_d = i_more ? sss_pkg::SORT_SCAN : sss_pkg::SORT_SWAP_LO;
      sss_pkg::SORT_SCAN:    if (!j_more) state_d = sss_pkg::SORT_SWAP_LO;
      sss_pkg::SORT_SWAP_LO: state_d = sss_pkg::SORT_SWAP_I;
      sss_pkg::SORT_SWAP_I:  state_d = i_last ? sss_pkg::SORT_MED_LO : sss_pkg::SORT_READ_I;
      sss_pkg::SORT_MED_LO:  state_d = sss_pkg::SORT_MED_HI;
      sss_pkg::SORT_MED_HI:  state_d = sss_pkg::SORT_MED_SUM;
      sss_pkg::SORT_MED_SUM: state_d = sss_pkg::SORT_IDLE;
      default:               state_d = sss_pkg::SORT_IDLE;
    endcase
  end

  // Memory port control and datapath updates.
  always_comb begin
    we     = 1'b0;
    waddr  = ld_wr_i.addr;
    wdata  = ld_wr_i.data;
    raddr  = i_q;
    i_d    = i_q;
    j_d    = j_q;
    lo_d   = lo_q;
    min_d  = min_q;
    vali_d = vali_q;
    meda_d = meda_q;
    med2_d = med2_q;
    unique case (state_q)
      sss_pkg::SORT_IDLE: begin
        we = ld_wr_i.we;
        if (req_i.start) begin
          i_d = '0;
        end
      end
      sss_pkg::SORT_READ_I: begin
        raddr = i_q;
      end
      sss_pkg::SORT_TAKE_I: begin
        min_d  = rdata_q;
        vali_d = rdata_q;
        lo_d   = i_q;
        j_d    = i_next[sss_pkg::AddrW-1:0];
        raddr  = i_next[sss_pkg::AddrW-1:0];
      end
      sss_pkg::SORT_SCAN: begin
        if (rdata_q < min_q) begin
          min_d = rdata_q;
          lo_d  = j_q;
        end
        j_d   = j_next[sss_pkg::AddrW-1:0];
        raddr = j_next[sss_pkg::AddrW-1:0];
      end
      sss_pkg::SORT_SWAP_LO: begin
        we    = 1'b1;
        waddr = lo_q;
        wdata = vali_q;
      end
      sss_pkg::SORT_SWAP_I: begin
        we    = 1'b1;
        waddr = i_q;
        wdata = min_q;
        if (!i_last) begin
          i_d = i_next[sss_pkg::AddrW-1:0];
        end
      end
      sss_pkg::SORT_MED_LO: begin
        // Even count reads the lower middle first; odd reads the middle twice.
        raddr = n_q[0] ? half[sss_pkg::AddrW-1:0] : half[sss_pkg::AddrW-1:0] - 1'b1;
      end
      sss_pkg::SORT_MED_HI: begin
        meda_d = rdata_q;
        raddr  = half[sss_pkg::AddrW-1:0];
      end
      sss_pkg::SORT_MED_SUM: begin
        med2_d = {1'b0, meda_q} + {1'b0, rdata_q};
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sss_pkg::SORT_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (req_i.start) begin
        done_q <= 1'b0;
      end else if (state_q == sss_pkg::SORT_MED_SUM) begin
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start && state_q == sss_pkg::SORT_IDLE) begin
      n_q <= req_i.n;
    end
    i_q    <= i_d;
    j_q    <= j_d;
    lo_q   <= lo_d;
    min_q  <= min_d;
    vali_q <= vali_d;
    meda_q <= meda_d;
    med2_q <= med2_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.med2 = med2_q;

  `ASSERT_IMPLIES(a_no_load_while_sorting, clk_i, rst_ni, state_q != sss_pkg::SORT_IDLE, !ld_wr_i.we && !req_i.start)

endmodule

`default_nettype wire
